@@ design/tsq_pkg.sv @@
// Shared types and constants for the eight-way touch stick quantizer.
// No dependencies; imported by touch_stick_eight_way_quantizer.
`default_nettype none

package tsq_pkg;

  // request codes on the tuser side channel
  localparam logic [1:0] REQ_BEGIN   = 2'd0;
  localparam logic [1:0] REQ_MOVE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_RADIUS   = 2'd2;

  localparam logic [10:0] RADIUS_RESET = 11'd64;

  // tan(22.5 deg) as 27146/65536
  localparam logic [14:0] CUT_NUM = 15'd27146;
  // floor(m*12/100) == (m * 3 * 5243) >> 17 for every 11-bit m
  localparam logic [14:0] DZ_RECIP = 15'd15729;
  localparam int unsigned DZ_SHIFT = 17;
  localparam logic [7:0]  DZ_MIN   = 8'd10;
  localparam logic [11:0] REACH_PAD = 12'd24;

  // last step of each sequencer phase
  localparam logic [4:0] MUL_LAST  = 5'd12;
  localparam logic [4:0] ROOT_LAST = 5'd20;
  localparam logic [4:0] DIV_LAST  = 5'd12;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ROOT = 6'b000100,
    ST_DIVX = 6'b001000,
    ST_DIVY = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

endpackage

`default_nettype wire

@@ design/touch_stick_eight_way_quantizer.sv @@
// Begin, release and unclamped moves go from input accept through the multiply
// phase to result valid; a move clamped to the pad circle also runs a 21-step
// square root and two divides on one shared compare/subtract unit.
// One item in flight; s_tready rises as the result is registered, so a new item
// is not taken before the result of the last one has been registered.
// Reset (rst, synchronous) clears origin and centers, radius 64. Depends on tsq_pkg.
`default_nettype none

module touch_stick_eight_way_quantizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // touch_x[11:0], touch_y[23:12]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // knob_x[13:0], knob_y[27:14], press_up[28], press_down[29], press_left[30],
  // press_right[31], touch_in_reach[32], zero fill[39:33]
  output logic [39:0]      m_tdata
);
  import tsq_pkg::*;

  state_t      state;
  logic [4:0]  cnt;

  logic [11:0] center_x, center_y;
  logic [10:0] radius;
  logic [11:0] origin_x, origin_y;

  logic [1:0]  req;
  logic [11:0] tx, ty;

  // arithmetic registers
  logic [26:0] p;
  logic [25:0] d2, e2;
  logic        clamp, nodz, reach;
  logic [7:0]  dz;
  logic [26:0] hx, vy;
  logic [22:0] numx, numy;
  logic [41:0] vsh;
  logic [21:0] rem;
  logic [20:0] root;
  logic [11:0] dsh, qx;

  // output register
  logic [13:0] knob_x, knob_y;
  logic        press_up, press_down, press_left, press_right, touch_in_reach;

  // combinational operands
  logic [12:0] dx_s, dy_s, rx_s, ry_s;
  logic [11:0] ax, ay, rx, ry;
  logic        dx_neg, dy_neg;
  logic [10:0] m;
  logic [11:0] r_pad, r_half3, reach_r;
  logic [12:0] r3;
  logic [11:0] mul_a;
  logic [14:0] mul_b;
  logic [23:0] sub_a, sub_b;
  logic [24:0] sub_d;
  logic        sub_ge;
  logic [32:0] n_load;
  logic [7:0]  dz_raw;
  logic [13:0] cx14, cy14, kx_n, ky_n;
  logic        horiz, vert, active;
  logic        up_n, down_n, left_n, right_n;

  assign dx_s   = {1'b0, tx} - {1'b0, origin_x};
  assign dy_s   = {1'b0, ty} - {1'b0, origin_y};
  assign rx_s   = {1'b0, tx} - {1'b0, center_x};
  assign ry_s   = {1'b0, ty} - {1'b0, center_y};
  assign dx_neg = dx_s[12];
  assign dy_neg = dy_s[12];
  assign ax     = dx_s[12] ? (~dx_s[11:0] + 12'd1) : dx_s[11:0];
  assign ay     = dy_s[12] ? (~dy_s[11:0] + 12'd1) : dy_s[11:0];
  assign rx     = rx_s[12] ? (~rx_s[11:0] + 12'd1) : rx_s[11:0];
  assign ry     = ry_s[12] ? (~ry_s[11:0] + 12'd1) : ry_s[11:0];

  assign m       = (radius == 11'd0) ? 11'd1 : radius;
  assign r_pad   = {1'b0, radius} + REACH_PAD;
  assign r3      = {2'b0, radius} + {1'b0, radius, 1'b0};
  assign r_half3 = r3[12:1];
  assign reach_r = (r_pad > r_half3) ? r_pad : r_half3;
  assign dz_raw  = p[DZ_SHIFT+7:DZ_SHIFT];

  // multiplier operand select, one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MUL) begin
      unique case (cnt)
        5'd0:    begin mul_a = ax;             mul_b = {3'b0, ax}; end
        5'd1:    begin mul_a = ay;             mul_b = {3'b0, ay}; end
        5'd2:    begin mul_a = rx;             mul_b = {3'b0, rx}; end
        5'd3:    begin mul_a = ry;             mul_b = {3'b0, ry}; end
        5'd4:    begin mul_a = reach_r;        mul_b = {3'b0, reach_r}; end
        5'd5:    begin mul_a = {1'b0, m};      mul_b = {4'b0, m}; end
        5'd6:    begin mul_a = {1'b0, m};      mul_b = DZ_RECIP; end
        5'd7:    begin mul_a = ax;             mul_b = CUT_NUM; end
        5'd8:    begin mul_a = {4'b0, dz};     mul_b = {7'b0, dz}; end
        5'd9:    begin mul_a = ay;             mul_b = CUT_NUM; end
        5'd10:   begin mul_a = ax;             mul_b = {4'b0, m}; end
        5'd11:   begin mul_a = ay;             mul_b = {4'b0, m}; end
        default: begin mul_a = '0;             mul_b = '0; end
      endcase
    end
  end

  // shared compare/subtract for square root and divide steps
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    if (state == ST_ROOT) begin
      sub_a = {rem, vsh[41:40]};
      sub_b = {1'b0, root, 2'b01};
    end else if (state == ST_DIVX || state == ST_DIVY) begin
      sub_a = {1'b0, rem, dsh[11]};
      sub_b = {2'b0, root, 1'b0};
    end
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[24];
  assign n_load = {1'b0, (state == ST_DIVX) ? numx : numy, 9'b0} + {12'b0, root};

  // result assembly
  assign cx14 = {2'b0, center_x};
  assign cy14 = {2'b0, center_y};

  always_comb begin
    kx_n = cx14;
    ky_n = cy14;
    if (req == REQ_MOVE) begin
      if (clamp) begin
        kx_n = dx_neg ? (cx14 - {2'b0, qx}) : (cx14 + {2'b0, qx});
        ky_n = dy_neg ? (cy14 - {2'b0, dsh}) : (cy14 + {2'b0, dsh});
      end else begin
        kx_n = cx14 + {dx_s[12], dx_s};
        ky_n = cy14 + {dy_s[12], dy_s};
      end
    end
  end

  always_comb begin
    horiz = 1'b0;
    vert  = 1'b0;
    priority if (ax == 12'd0) begin
      vert = 1'b1;
    end else if ({ay, 16'b0} <= {1'b0, hx}) begin
      horiz = 1'b1;
    end else if ({1'b0, vy} >= {ax, 16'b0}) begin
      vert = 1'b1;
    end else begin
      horiz = 1'b1;
      vert  = 1'b1;
    end
  end

  assign active  = (req == REQ_MOVE) && !nodz;
  assign right_n = active && horiz && !dx_neg && (ax != 12'd0);
  assign left_n  = active && horiz && !(!dx_neg && (ax != 12'd0));
  assign up_n    = active && vert && dy_neg;
  assign down_n  = active && vert && !dy_neg;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {7'b0, touch_in_reach, press_right, press_left, press_down, press_up,
                     knob_y, knob_x};

  // datapath registers
  always_ff @(posedge clk) begin
    p <= {15'b0, mul_a} * {12'b0, mul_b};
    if (s_tvalid && s_tready) begin
      req <= s_tuser;
      tx  <= s_tdata[11:0];
      ty  <= s_tdata[23:12];
    end
    unique case (state)
      ST_MUL: begin
        unique case (cnt)
          5'd1:    d2 <= p[25:0];
          5'd2:    d2 <= d2 + p[25:0];
          5'd3:    e2 <= p[25:0];
          5'd4:    e2 <= e2 + p[25:0];
          5'd5:    reach <= (e2 <= {2'b0, p[23:0]});
          5'd6:    clamp <= (d2 > {4'b0, p[21:0]});
          5'd7:    dz <= (dz_raw < DZ_MIN) ? DZ_MIN : dz_raw;
          5'd8:    hx <= p;
          5'd9:    nodz <= (d2 < {10'b0, p[15:0]});
          5'd10:   vy <= p;
          5'd11:   numx <= p[22:0];
          5'd12:   numy <= p[22:0];
          default: ;
        endcase
        if (cnt == MUL_LAST) begin
          vsh  <= {d2, 16'b0};
          rem  <= '0;
          root <= '0;
        end
      end
      ST_ROOT: begin
        rem  <= sub_ge ? sub_d[21:0] : sub_a[21:0];
        root <= {root[19:0], sub_ge};
        vsh  <= {vsh[39:0], 2'b0};
      end
      ST_DIVX, ST_DIVY: begin
        if (cnt == 5'd0) begin
          // hold the x quotient before the y divide reuses the shift register
          if (state == ST_DIVY) qx <= dsh;
          rem <= {1'b0, n_load[32:12]};
          dsh <= n_load[11:0];
        end else begin
          rem <= sub_ge ? sub_d[21:0] : sub_a[21:0];
          dsh <= {dsh[10:0], sub_ge};
        end
      end
      default: ;
    endcase
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      knob_x         <= kx_n;
      knob_y         <= ky_n;
      press_up       <= up_n;
      press_down     <= down_n;
      press_left     <= left_n;
      press_right    <= right_n;
      touch_in_reach <= reach;
    end
  end

  // control, configuration and drag origin
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      center_x <= '0;
      center_y <= '0;
      radius   <= RADIUS_RESET;
      origin_x <= '0;
      origin_y <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_addr)
          CFG_CENTER_X: center_x <= cfg_data;
          CFG_CENTER_Y: center_y <= cfg_data;
          CFG_RADIUS:   radius   <= cfg_data[10:0];
          default:      ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              REQ_BEGIN: begin
                origin_x <= s_tdata[11:0];
                origin_y <= s_tdata[23:12];
              end
              REQ_MOVE: ;
              default: begin
                origin_x <= center_x;
                origin_y <= center_y;
              end
            endcase
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= (req == REQ_MOVE && clamp) ? ST_ROOT : ST_DONE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_ROOT: begin
          if (cnt == ROOT_LAST) begin
            cnt   <= '0;
            state <= ST_DIVX;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DIVX: begin
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= ST_DIVY;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DIVY: begin
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DONE: begin
          // advance once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
